// File: hw/rtl/box_clip_against_limit_set_top_defines.svh
// Assertion macros shared by the box clipper checker.
// No dependencies; expects clk and rst in the scope where a macro is used.
`ifndef BOX_CLIP_AGAINST_LIMIT_SET_TOP_DEFINES_SVH
`define BOX_CLIP_AGAINST_LIMIT_SET_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BCLIP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bclip check failed");

// Next-cycle implication, disabled during reset
`define BCLIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bclip check failed");

`endif

// File: hw/rtl/bclip_pkg.sv
// Shared types, sizes and action codes for the box clipper.
// No dependencies.
package bclip_pkg;

  localparam int MAX_LIMITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int COORD_W    = 32;
  localparam int LIMIT_IDX_W = (MAX_LIMITS > 1) ? $clog2(MAX_LIMITS) : 1;
  localparam int CNT_W      = 5;

  localparam logic [COORD_W-1:0] FRAC_MASK = COORD_W'((64'd1 << FRAC_BITS) - 64'd1);

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_LIMIT = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } box_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } limit_t;

  // clip result handed from the clip unit to the sequencer
  typedef struct packed {
    logic hit;
    box_t box;
  } clip_res_t;

  function automatic logic is_whole(input coord_t v);
    return (v & FRAC_MASK) == '0;
  endfunction

endpackage

// File: hw/rtl/bclip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bclip_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/bclip_clip.sv
// Intersects an ordered box with one limit rectangle and restores winding.
// Depends on bclip_pkg.
module bclip_clip (
  input  bclip_pkg::box_t      ordered,
  input  logic                 rev,
  input  bclip_pkg::limit_t    lim,
  output bclip_pkg::clip_res_t res
);
  import bclip_pkg::*;

  coord_t cx1, cy1, cx2, cy2;

  // max of lower edges, min of upper edges
  always_comb begin
    cx1 = (ordered.ax < lim.left)   ? lim.left   : ordered.ax;
    cy1 = (ordered.ay < lim.top)    ? lim.top    : ordered.ay;
    cx2 = (ordered.bx > lim.right)  ? lim.right  : ordered.bx;
    cy2 = (ordered.by > lim.bottom) ? lim.bottom : ordered.by;
  end

  // empty check and x re-swap for odd winding parity
  always_comb begin
    res.hit    = (cy2 > cy1) && (cx2 > cx1);
    res.box.ay = cy1;
    res.box.by = cy2;
    res.box.ax = rev ? cx2 : cx1;
    res.box.bx = rev ? cx1 : cx2;
  end

endmodule

// File: hw/rtl/box_clip_against_limit_set_top.sv
// Box clipper top level: command port, limit table RAM, clip sequencer.
// Depends on bclip_pkg, bclip_ram and bclip_clip.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  command | start, busy          | action, entry_index, corner_*, snap_to_pixel
//  result  | strobe (no stall)    | out_*, last_of_run, all_aligned, stored_count
//  config  | cfg_valid, cfg_ready | cfg_data (limit count)
//
// Limit writes, clears, unused actions and dropped adds complete from idle; busy stays low.
// An add with limits in use does one RAM read and one clip for each of
// min(limit_count, MAX_LIMITS) entries, then a flush of the held result; with none,
// only the flush. One result is held back so the last one can be flagged.
// Reset: synchronous rst clears control, count (0) and aligned flag (1);
// the limit table is not cleared. The result side cannot stall.
module box_clip_against_limit_set_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                action,
  input  logic [3:0]                entry_index,
  input  bclip_pkg::coord_t         corner_ax,
  input  bclip_pkg::coord_t         corner_ay,
  input  bclip_pkg::coord_t         corner_bx,
  input  bclip_pkg::coord_t         corner_by,
  input  logic                      snap_to_pixel,
  output logic                      strobe,
  output bclip_pkg::coord_t         out_ax,
  output bclip_pkg::coord_t         out_ay,
  output bclip_pkg::coord_t         out_bx,
  output bclip_pkg::coord_t         out_by,
  output logic                      last_of_run,
  output logic                      all_aligned,
  output logic [31:0]               stored_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bclip_pkg::CNT_W-1:0] cfg_data
);
  import bclip_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state;

  logic [CNT_W-1:0]       limit_count;
  logic [31:0]            box_total;
  logic                   aligned_flag;

  logic [LIMIT_IDX_W-1:0] proc_idx;
  logic [LIMIT_IDX_W-1:0] last_idx;
  box_t                   ordered;
  logic                   rev;

  // held result, emitted once the next one or the end is known
  box_t                   pend_box;
  logic                   pend_valid;
  logic                   pend_aligned;
  logic [31:0]            pend_count;

  logic                   accept;
  box_t                   in_box;
  logic                   degen;
  logic                   no_limits;
  logic [CNT_W-1:0]       used;
  box_t                   ord_next;
  logic                   rev_next;

  logic                   ram_we;
  logic [LIMIT_IDX_W-1:0] ram_raddr;
  limit_t                 ram_wdata;
  limit_t                 ram_rdata;
  clip_res_t              clip;

  logic [31:0]            total_inc;
  logic                   store_aligned;
  box_t                   store_box;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // optional snap to whole pixels
  always_comb begin
    in_box.ax = snap_to_pixel ? (corner_ax & ~FRAC_MASK) : corner_ax;
    in_box.ay = snap_to_pixel ? (corner_ay & ~FRAC_MASK) : corner_ay;
    in_box.bx = snap_to_pixel ? (corner_bx & ~FRAC_MASK) : corner_bx;
    in_box.by = snap_to_pixel ? (corner_by & ~FRAC_MASK) : corner_by;
  end

  assign degen     = (in_box.ay == in_box.by) || (in_box.ax == in_box.bx);
  assign no_limits = (limit_count == '0);
  assign used      = (32'(limit_count) > MAX_LIMITS) ? CNT_W'(MAX_LIMITS) : limit_count;

  // normalize corners, tracking swap parity
  always_comb begin
    ord_next.ax = (in_box.ax < in_box.bx) ? in_box.ax : in_box.bx;
    ord_next.bx = (in_box.ax < in_box.bx) ? in_box.bx : in_box.ax;
    ord_next.ay = (in_box.ay < in_box.by) ? in_box.ay : in_box.by;
    ord_next.by = (in_box.ay < in_box.by) ? in_box.by : in_box.ay;
    rev_next    = (in_box.ax >= in_box.bx) ^ (in_box.ay >= in_box.by);
  end

  // limit table
  assign ram_we           = accept && (action == ACT_LIMIT) && (32'(entry_index) < MAX_LIMITS);
  assign ram_wdata.left   = corner_ax;
  assign ram_wdata.top    = corner_ay;
  assign ram_wdata.right  = corner_bx;
  assign ram_wdata.bottom = corner_by;
  assign ram_raddr        = (state == ST_RUN) ? (proc_idx + 1'b1) : '0;

  bclip_ram #(
    .WIDTH ($bits(limit_t)),
    .DEPTH (MAX_LIMITS)
  ) u_limits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (LIMIT_IDX_W'(entry_index)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bclip_clip u_clip (
    .ordered (ordered),
    .rev     (rev),
    .lim     (ram_rdata),
    .res     (clip)
  );

  // box being stored this cycle: pass-through in idle, clip result in run
  assign store_box     = (state == ST_RUN) ? clip.box : in_box;
  assign total_inc     = (box_total == 32'hFFFF_FFFF) ? box_total : box_total + 32'd1;
  assign store_aligned = aligned_flag && is_whole(store_box.ax) && is_whole(store_box.ay)
                         && is_whole(store_box.bx) && is_whole(store_box.by);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      limit_count <= cfg_data;
    end
  end

  // sequencer, running totals and held result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      box_total    <= '0;
      aligned_flag <= 1'b1;
      pend_valid   <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          strobe <= 1'b0;
          if (accept) begin
            case (action)
              ACT_ADD: begin
                if (!degen) begin
                  if (no_limits) begin
                    pend_box     <= in_box;
                    pend_valid   <= 1'b1;
                    pend_count   <= total_inc;
                    pend_aligned <= store_aligned;
                    box_total    <= total_inc;
                    aligned_flag <= store_aligned;
                    state        <= ST_FLUSH;
                  end else begin
                    ordered  <= ord_next;
                    rev      <= rev_next;
                    proc_idx <= '0;
                    last_idx <= LIMIT_IDX_W'(used - 1'b1);
                    state    <= ST_RUN;
                  end
                end
              end
              ACT_CLEAR: begin
                box_total    <= '0;
                aligned_flag <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          strobe <= clip.hit && pend_valid;
          if (clip.hit) begin
            // release the previous hit, hold the new one
            if (pend_valid) begin
              out_ax       <= pend_box.ax;
              out_ay       <= pend_box.ay;
              out_bx       <= pend_box.bx;
              out_by       <= pend_box.by;
              last_of_run  <= 1'b0;
              all_aligned  <= pend_aligned;
              stored_count <= pend_count;
            end
            pend_box     <= clip.box;
            pend_valid   <= 1'b1;
            pend_count   <= total_inc;
            pend_aligned <= store_aligned;
            box_total    <= total_inc;
            aligned_flag <= store_aligned;
          end
          proc_idx <= proc_idx + 1'b1;
          if (proc_idx == last_idx) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          strobe <= pend_valid;
          if (pend_valid) begin
            out_ax       <= pend_box.ax;
            out_ay       <= pend_box.ay;
            out_bx       <= pend_box.bx;
            out_by       <= pend_box.by;
            last_of_run  <= 1'b1;
            all_aligned  <= pend_aligned;
            stored_count <= pend_count;
          end
          pend_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          strobe <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/bclip_chk.sv
// Port-level checker for the box clipper, bound to the top level.
// Depends on bclip_pkg and box_clip_against_limit_set_top_defines.svh.
`include "box_clip_against_limit_set_top_defines.svh"

module bclip_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  action,
  input logic                        strobe,
  input logic                        last_of_run,
  input logic [31:0]                 stored_count
);
  import bclip_pkg::*;

  // nothing comes out in the cycle after reset
  `BCLIP_ASSERT_NOW(a_quiet_after_rst, $past(rst), !strobe)

  // an accepted item never produces a result in the following cycle
  `BCLIP_ASSERT_NEXT(a_no_strobe_after_accept, start && !busy, !strobe)

  // limit writes, clears and unused actions finish at once
  `BCLIP_ASSERT_NEXT(a_short_items, start && !busy && (action != ACT_ADD), !busy)

  // a non-final result always has more of its run still in progress
  `BCLIP_ASSERT_NOW(a_more_to_come, strobe && !last_of_run, busy)

  // results within one run count up by one, or stay saturated
  `BCLIP_ASSERT_NOW(a_count_steps,
    strobe && $past(strobe) && !$past(last_of_run),
    (stored_count == $past(stored_count) + 32'd1) || (stored_count == 32'hFFFF_FFFF))

endmodule

bind box_clip_against_limit_set_top bclip_chk u_bclip_chk (.*);

// File: tb/sv/box_clip_against_limit_set_top_tb.sv
// Testbench for box_clip_against_limit_set_top: directed table then random commands,
// every result checked against given values or an in-bench clipping predictor.
// Depends on bclip_pkg and the box_clip_against_limit_set_top RTL.
module box_clip_against_limit_set_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bclip_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam coord_t CMIN = 32'sh8000_0000;
  localparam coord_t CMAX = 32'sh7FFF_FFFF;
  localparam coord_t PIXEL_FRAC = coord_t'((1 << FRAC_BITS) - 1);
  // an add runs at most MAX_LIMITS limit entries plus a flush; leave margin
  localparam int SETTLE = MAX_LIMITS + 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 18;

  typedef struct packed {
    logic [1:0] act;
    logic [3:0] idx;
    coord_t     ax;
    coord_t     ay;
    coord_t     bx;
    coord_t     by;
    logic       snap;
  } cmd_t;

  typedef struct packed {
    coord_t      ax;
    coord_t      ay;
    coord_t      bx;
    coord_t      by;
    logic        last;
    logic        aligned;
    logic [31:0] count;
  } clip_out_t;

  typedef enum {CHECK_MODEL, CHECK_NOTHING, CHECK_GIVEN} check_e;

  typedef struct {
    cmd_t      cmd;
    check_e    how;
    clip_out_t given;
  } dir_row_t;

  // DUT ports
  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = ACT_ADD;
  logic [3:0]  entry_index = '0;
  coord_t      corner_ax = '0;
  coord_t      corner_ay = '0;
  coord_t      corner_bx = '0;
  coord_t      corner_by = '0;
  logic        snap_to_pixel = 1'b0;
  logic        strobe;
  coord_t      out_ax;
  coord_t      out_ay;
  coord_t      out_bx;
  coord_t      out_by;
  logic        last_of_run;
  logic        all_aligned;
  logic [31:0] stored_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  box_clip_against_limit_set_top u_dut (.*);

  // predictor state
  coord_t           lim_left   [MAX_LIMITS];
  coord_t           lim_top    [MAX_LIMITS];
  coord_t           lim_right  [MAX_LIMITS];
  coord_t           lim_bottom [MAX_LIMITS];
  logic [31:0]      boxes_stored = '0;
  logic             aligned_so_far = 1'b1;
  logic [CNT_W-1:0] clip_count = '0;

  clip_out_t expected_boxes[$];
  clip_out_t fresh_boxes[$];
  dir_row_t  plan[$];

  int mismatches = 0;
  int boxes_checked = 0;
  int n_adds = 0;
  int n_limit_writes = 0;
  int n_other = 0;
  int widest_fanout = 0;
  int cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("box_clip_against_limit_set_top: mismatch");
      $finish;
    end
  end

  // counts one more stored box and returns it as a result
  function automatic clip_out_t store_box(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    clip_out_t r;
    if (boxes_stored != '1) boxes_stored++;
    if (aligned_so_far) aligned_so_far = ((ax | ay | bx | by) & PIXEL_FRAC) == '0;
    r = {ax, ay, bx, by, 1'b0, aligned_so_far, boxes_stored};
    return r;
  endfunction

  // clipping predictor: fills fresh_boxes with the results of one command
  task automatic clip_predict(input cmd_t c);
    coord_t ax, ay, bx, by, x1, x2, y1, y2, cx1, cy1, cx2, cy2;
    logic flip;
    int used;
    ax = c.ax; ay = c.ay; bx = c.bx; by = c.by;
    flip = 1'b0;
    fresh_boxes.delete();
    case (c.act)
      ACT_LIMIT: begin
        if (int'(c.idx) < MAX_LIMITS) begin
          lim_left[c.idx] = ax;
          lim_top[c.idx] = ay;
          lim_right[c.idx] = bx;
          lim_bottom[c.idx] = by;
        end
      end
      ACT_CLEAR: begin
        boxes_stored = '0;
        aligned_so_far = 1'b1;
      end
      ACT_ADD: begin
        if (c.snap) begin
          ax = ax & ~PIXEL_FRAC;
          ay = ay & ~PIXEL_FRAC;
          bx = bx & ~PIXEL_FRAC;
          by = by & ~PIXEL_FRAC;
        end
        // zero width or height: dropped
        if (ax != bx && ay != by) begin
          used = (int'(clip_count) > MAX_LIMITS) ? MAX_LIMITS : int'(clip_count);
          if (used == 0) begin
            fresh_boxes.push_back(store_box(ax, ay, bx, by));
          end else begin
            // normalize; odd number of swaps means the x pair goes back reversed
            if (ax < bx) begin
              x1 = ax; x2 = bx;
            end else begin
              x1 = bx; x2 = ax; flip = ~flip;
            end
            if (ay < by) begin
              y1 = ay; y2 = by;
            end else begin
              y1 = by; y2 = ay; flip = ~flip;
            end
            for (int n = 0; n < used; n++) begin
              cx1 = (x1 < lim_left[n]) ? lim_left[n] : x1;
              cy1 = (y1 < lim_top[n]) ? lim_top[n] : y1;
              cx2 = (x2 > lim_right[n]) ? lim_right[n] : x2;
              cy2 = (y2 > lim_bottom[n]) ? lim_bottom[n] : y2;
              if (cy2 > cy1 && cx2 > cx1) begin
                if (flip) fresh_boxes.push_back(store_box(cx2, cy1, cx1, cy2));
                else fresh_boxes.push_back(store_box(cx1, cy1, cx2, cy2));
              end
            end
          end
          if (fresh_boxes.size() > 0) fresh_boxes[fresh_boxes.size()-1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // result checker: the receiver never stalls, so every strobe is a result
  always @(posedge clk) begin : check_results
    clip_out_t want;
    clip_out_t got;
    if (!rst && strobe === 1'b1) begin
      got = {out_ax, out_ay, out_bx, out_by, last_of_run, all_aligned, stored_count};
      boxes_checked++;
      if (expected_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ax=%h ay=%h bx=%h by=%h last=%b aligned=%b count=%0d",
                   got.ax, got.ay, got.bx, got.by, got.last, got.aligned, got.count);
      end else begin
        want = expected_boxes.pop_front();
        if (got.ax !== want.ax || got.ay !== want.ay || got.bx !== want.bx ||
            got.by !== want.by || got.last !== want.last ||
            got.aligned !== want.aligned || got.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch, expected: ax=%h ay=%h bx=%h by=%h last=%b aligned=%b count=%0d",
                     want.ax, want.ay, want.bx, want.by, want.last, want.aligned, want.count);
            $display("                   actual: ax=%h ay=%h bx=%h by=%h last=%b aligned=%b count=%0d",
                     got.ax, got.ay, got.bx, got.by, got.last, got.aligned, got.count);
          end
        end
      end
    end
  end

  // send one item, record what it should produce, then hold start low for the given gap
  task automatic issue_command(input cmd_t c, input check_e how, input clip_out_t given,
                               input int gap);
    action <= c.act;
    entry_index <= c.idx;
    corner_ax <= c.ax;
    corner_ay <= c.ay;
    corner_bx <= c.bx;
    corner_by <= c.by;
    snap_to_pixel <= c.snap;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    clip_predict(c);
    if (how == CHECK_MODEL) begin
      foreach (fresh_boxes[i]) expected_boxes.push_back(fresh_boxes[i]);
    end else if (how == CHECK_GIVEN) begin
      expected_boxes.push_back(given);
    end
    if (c.act == ACT_ADD) begin
      n_adds++;
      if (fresh_boxes.size() > widest_fanout) widest_fanout = fresh_boxes.size();
    end else if (c.act == ACT_LIMIT) begin
      n_limit_writes++;
    end else begin
      n_other++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every result is in and the block has gone quiet
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_boxes.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limit_count(input logic [CNT_W-1:0] v);
    wait_idle();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    clip_count = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly small coordinates near the limits, some extremes and raw words
  function automatic coord_t pick_coord();
    coord_t v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: v = CMIN;
          1: v = CMAX;
          2: v = -32'sd1;
          default: v = '0;
        endcase
      end
      default: begin
        v = coord_t'($urandom_range(0, 32'h4000)) - 32'sh2000;
        if ($urandom_range(0, 1)) v = v & ~PIXEL_FRAC;
      end
    endcase
    return v;
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    c.act = ACT_ADD;
    c.idx = 4'($urandom_range(0, 15));
    c.snap = 1'($urandom_range(0, 1));
    c.ax = pick_coord();
    c.ay = pick_coord();
    c.bx = pick_coord();
    c.by = pick_coord();
    if (sel < 60) begin
      // well-formed add, now and then flat
      if ($urandom_range(0, 19) == 0) c.bx = c.ax;
      else if ($urandom_range(0, 19) == 0) c.by = c.ay;
    end else if (sel < 80) begin
      c.act = ACT_LIMIT;
      if ($urandom_range(0, 9) != 0) begin
        c.ax = coord_t'($urandom_range(0, 32'h4000)) - 32'sh2000;
        c.ay = coord_t'($urandom_range(0, 32'h4000)) - 32'sh2000;
        c.bx = c.ax + coord_t'($urandom_range(32'h80, 32'h3000));
        c.by = c.ay + coord_t'($urandom_range(32'h80, 32'h3000));
        // reversed entry: never intersects
        if ($urandom_range(0, 6) == 0) begin
          c.bx = c.ax - coord_t'($urandom_range(0, 32'h100));
        end
      end
    end else if (sel < 87) begin
      c.act = ACT_CLEAR;
      c.ax = $urandom; c.ay = $urandom; c.bx = $urandom; c.by = $urandom;
    end else if (sel < 92) begin
      c.act = ACT_UNUSED;
    end else begin
      // raw noise on every field
      c.act = 2'($urandom_range(0, 3));
      c.ax = $urandom; c.ay = $urandom; c.bx = $urandom; c.by = $urandom;
    end
    return c;
  endfunction

  function automatic dir_row_t plan_row(logic [1:0] act, logic [3:0] idx, coord_t ax, coord_t ay,
                                        coord_t bx, coord_t by, logic snap, check_e how,
                                        clip_out_t given);
    dir_row_t r;
    r.cmd = '{act, idx, ax, ay, bx, by, snap};
    r.how = how;
    r.given = given;
    return r;
  endfunction

  // stimulus
  initial begin : drive
    int settings[8];
    bit no_idle;
    // no limits: boxes pass through, extremes, snapping, flat boxes, unused action
    plan.push_back(plan_row(ACT_ADD, 4'd0, 32'sh100, 32'sh200, 32'sh300, 32'sh400, 1'b0,
                            CHECK_GIVEN, {32'sh100, 32'sh200, 32'sh300, 32'sh400, 1'b1, 1'b1, 32'd1}));
    plan.push_back(plan_row(ACT_ADD, 4'd0, CMIN, CMIN, CMAX, CMAX, 1'b0,
                            CHECK_GIVEN, {CMIN, CMIN, CMAX, CMAX, 1'b1, 1'b0, 32'd2}));
    plan.push_back(plan_row(ACT_ADD, 4'd15, CMAX, CMAX, CMIN, CMIN, 1'b1, CHECK_GIVEN,
                            {32'sh7FFF_FF00, 32'sh7FFF_FF00, CMIN, CMIN, 1'b1, 1'b0, 32'd3}));
    plan.push_back(plan_row(ACT_CLEAR, 4'd0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_ADD, 4'd0, 32'sh180, 32'sh80, 32'sh1C0, 32'shF0, 1'b1,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_ADD, 4'd0, CMAX, 32'sh0, CMAX, 32'sh100, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_UNUSED, 4'd15, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b1,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_ADD, 4'd0, 32'sh200, 32'sh300, 32'sh100, 32'sh100, 1'b0,
                            CHECK_GIVEN, {32'sh200, 32'sh300, 32'sh100, 32'sh100, 1'b1, 1'b1, 32'd1}));
    // fill the whole limit table: ordinary, full-range, reversed and flat entries
    plan.push_back(plan_row(ACT_LIMIT, 4'd0, 32'sh0, 32'sh0, 32'sh1000, 32'sh1000, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd1, CMIN, CMIN, CMAX, CMAX, 1'b0, CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd2, 32'sh1000, 32'sh0, 32'sh0, 32'sh1000, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd3, 32'sh0, 32'sh800, 32'sh2000, 32'sh800, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd4, -32'sh1000, -32'sh1000, 32'sh80, 32'sh80, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd5, 32'sh400, -32'sh2000, 32'sh1400, 32'sh2000, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd6, -32'sh2000, 32'sh400, 32'sh2000, 32'sh1400, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd7, 32'sh10, 32'sh20, 32'sh1F0, 32'sh1E0, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd8, -32'sh800, -32'sh800, 32'sh800, 32'sh800, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd9, 32'sh1800, 32'sh1800, 32'sh2000, 32'sh2000, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd10, CMIN, 32'sh0, 32'sh0, CMAX, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd11, 32'sh0, CMIN, CMAX, 32'sh0, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd12, -32'sh2000, -32'sh2000, -32'sh1000, -32'sh1000,
                            1'b0, CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd13, 32'sh7F, 32'sh7F, 32'sh181, 32'sh181, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd14, 32'sh100, 32'sh100, 32'sh100, 32'sh100, 1'b0,
                            CHECK_NOTHING, '0));
    plan.push_back(plan_row(ACT_LIMIT, 4'd15, -32'sh1800, 32'sh200, 32'sh600, 32'sh1C00, 1'b0,
                            CHECK_NOTHING, '0));

    // limit counts: one, full table, above table size, small, off, random
    settings = '{1, 16, 31, 4, 0, 17, 9, 2};
    settings[6] = $urandom_range(0, 31);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_limit_count('0);

    // directed table
    foreach (plan[i]) issue_command(plan[i].cmd, plan[i].how, plan[i].given, pick_gap());

    // random phases, one limit count each, set while the block is idle
    foreach (settings[p]) begin
      set_limit_count(CNT_W'(settings[p]));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++)
        issue_command(random_command(), CHECK_MODEL, '0, no_idle ? 0 : pick_gap());
    end

    wait_idle();
    $display("covered %0d adds, %0d limit writes, %0d clear/unused items; %0d boxes checked",
             n_adds, n_limit_writes, n_other, boxes_checked);
    $display("limit counts 0,1,2,4,16,17,31 and %0d; widest add gave %0d boxes",
             settings[6], widest_fanout);
    if (mismatches == 0 && expected_boxes.size() == 0) begin
      $display("box_clip_against_limit_set_top: match");
    end else begin
      $display("box_clip_against_limit_set_top: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bclip_pkg.sv
hw/rtl/bclip_ram.sv
hw/rtl/bclip_clip.sv
hw/rtl/box_clip_against_limit_set_top.sv
hw/rtl/bclip_chk.sv
tb/sv/box_clip_against_limit_set_top_tb.sv
